[rtl/olad_pkg.sv]
// Package for the ordered list block: sizes, request/response items, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olad_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } olad_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } olad_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } olad_state_t;

endpackage

`default_nettype wire

[rtl/olad_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module olad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/ordered_list_append_delete_top.sv]
// Ordered list top level: request FSM around one entry RAM.
// Depends on olad_pkg and olad_ram.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. Append, append to a
// full list and delete on an empty list answer in the cycle after the item is
// taken and keep busy low. A delete on a non-empty list holds busy, then
// answers when busy falls again: the entry RAM has one read port and
// one write port, so the search from the head and the move-up of the entries
// behind a hit go through it one entry per cycle. Each answer shows on rsp for
// a single cycle with done high; there is no way to hold it off.
module ordered_list_append_delete_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire olad_pkg::olad_req_t req,
    output logic                    done,
    output olad_pkg::olad_rsp_t     rsp
);

    import olad_pkg::*;

    olad_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic                       done_reg, done_next;
    olad_rsp_t                  rsp_reg, rsp_next;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [VALUE_W-1:0]         wr_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic [VALUE_W-1:0]         rd_data;

    logic [CNT_W-1:0]           pos_inc;
    logic [CNT_W-1:0]           pos_dec;
    logic [CNT_W-1:0]           cnt_dec;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       last;
    logic                       hit;

    olad_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_inc = pos_reg + CNT_W'(1);
    assign pos_dec = pos_reg - CNT_W'(1);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign last    = (pos_inc == cnt_reg);
    assign hit     = (rd_data == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_dec[ADDR_W-1:0];
        wr_data    = rd_data;
        rd_addr    = pos_inc[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (start)
                begin
                    if (req.mode == MODE_APPEND)
                    begin
                        done_next = 1'b1;
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            rsp_next.status = STATUS_FULL;
                            rsp_next.count  = COUNT_W'(cnt_reg);
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = cnt_reg[ADDR_W-1:0];
                            wr_data         = req.value;
                            cnt_next        = cnt_inc;
                            rsp_next.status = STATUS_DONE;
                            rsp_next.count  = COUNT_W'(cnt_inc);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = STATUS_NOT_FOUND;
                        rsp_next.count  = '0;
                    end
                    else
                    begin
                        key_next   = req.value;
                        pos_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // rd_data holds entry[pos]; entry[pos+1] is read ahead
                if (hit)
                begin
                    if (last)
                    begin
                        cnt_next        = cnt_dec;
                        done_next       = 1'b1;
                        rsp_next.status = STATUS_DONE;
                        rsp_next.count  = COUNT_W'(cnt_dec);
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = S_SHIFT;
                    end
                end
                else if (last)
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STATUS_NOT_FOUND;
                    rsp_next.count  = COUNT_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            S_SHIFT:
            begin
                // entry[pos] moves up to pos-1
                wr_en = 1'b1;
                if (last)
                begin
                    cnt_next        = cnt_dec;
                    done_next       = 1'b1;
                    rsp_next.status = STATUS_DONE;
                    rsp_next.count  = COUNT_W'(cnt_dec);
                    state_next      = S_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[rtl/olad_chk.sv]
// Port-level checks for the ordered list top level, bound to it below.
// Depends on olad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olad_chk (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire olad_pkg::olad_req_t req,
    input wire logic                done,
    input wire olad_pkg::olad_rsp_t rsp
);

    import olad_pkg::*;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.count <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_FULL) |-> (rsp.count == COUNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_append_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.mode == MODE_APPEND) |=> (done && !busy))
        else $error("append not answered in one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("answer while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STATUS_DONE || rsp.status == STATUS_NOT_FOUND ||
                  rsp.status == STATUS_FULL))
        else $error("undefined status");

endmodule

bind ordered_list_append_delete_top olad_chk u_olad_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the ordered list block: append and delete items,
// with responses checked against an in-bench list predictor.
// Depends on olad_pkg and ordered_list_append_delete_top.
`timescale 1ns / 1ps

module tb;

    import olad_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    olad_req_t req = '0;
    logic      done;
    olad_rsp_t rsp;

    olad_req_t pending_items [$];
    olad_rsp_t expected_rsps [$];

    logic [VALUE_W-1:0] held_values [CAPACITY];
    int                 held_count = 0;

    int failures   = 0;
    int issued     = 0;
    int gap_left   = 0;
    int quiet_cnt  = 0;

    ordered_list_append_delete_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic olad_rsp_t list_update(olad_req_t r);
        olad_rsp_t rsp_out;
        int        hit;
        int        i;
        hit = -1;
        rsp_out.status = STATUS_NOT_FOUND;
        if (r.mode == MODE_APPEND)
        begin
            if (held_count >= CAPACITY)
                rsp_out.status = STATUS_FULL;
            else
            begin
                held_values[held_count] = r.value;
                held_count++;
                rsp_out.status = STATUS_DONE;
            end
        end
        else
        begin
            for (i = 0; i < held_count; i++)
                if (hit < 0 && held_values[i] == r.value)
                    hit = i;
            if (hit >= 0)
            begin
                for (i = hit; i + 1 < held_count; i++)
                    held_values[i] = held_values[i + 1];
                held_count--;
                rsp_out.status = STATUS_DONE;
            end
        end
        rsp_out.count = COUNT_W'(held_count);
        return rsp_out;
    endfunction

    task automatic queue_item(logic mode, logic [VALUE_W-1:0] value);
        olad_req_t r;
        r.mode  = mode;
        r.value = value;
        pending_items.push_back(r);
    endtask

    function automatic logic [VALUE_W-1:0] pool_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // driver: at most one nonblocking write of start per edge
    always @(posedge clk)
    begin
        logic taken;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_rsps.push_back(list_update(req));
            if (!start || taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    if (!(issued >= 250 && issued < 400) && $urandom_range(99) < 8)
                    begin
                        gap_left = $urandom_range(19);
                        start <= 1'b0;
                    end
                    else
                    begin
                        req   <= pending_items.pop_front();
                        start <= 1'b1;
                        issued++;
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        olad_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response, status %0d count %0d",
                         $time, rsp.status, rsp.count);
                failures++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                    failures++;
                end
                if (rsp.count !== want.count)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want.count, rsp.count);
                    failures++;
                end
            end
        end
    end

    // watchdog: cycles with no item taken and no response
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            quiet_cnt <= 0;
        else if (quiet_cnt >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cnt <= quiet_cnt + 1;
    end

    initial
    begin
        logic [VALUE_W-1:0] pool [10];
        int                 pool_n;
        int                 seg_len;
        int                 append_pct;
        int                 n;
        int                 k;

        // directed: empty delete, extremes, duplicates, absent, head/tail, full
        queue_item(MODE_DELETE, 32'h0000_0005);
        queue_item(MODE_APPEND, 32'h8000_0000);
        queue_item(MODE_APPEND, 32'h7fff_ffff);
        queue_item(MODE_APPEND, 32'hffff_ffff);
        queue_item(MODE_APPEND, 32'h0000_0000);
        queue_item(MODE_APPEND, 32'h0000_0005);
        queue_item(MODE_APPEND, 32'h0000_0005);
        queue_item(MODE_APPEND, 32'h0000_0007);
        queue_item(MODE_DELETE, 32'h0000_0005);
        queue_item(MODE_DELETE, 32'h0000_0063);
        queue_item(MODE_DELETE, 32'h8000_0000);
        queue_item(MODE_DELETE, 32'h0000_0007);
        for (k = 0; k < 11; k++)
            queue_item(MODE_APPEND, $urandom);
        queue_item(MODE_APPEND, 32'h0000_1234);
        queue_item(MODE_APPEND, 32'h0000_4321);
        queue_item(MODE_DELETE, 32'h0000_4321);
        queue_item(MODE_DELETE, 32'hffff_ffff);

        // random segments around a small value pool so deletes mostly hit
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            pool_n = $urandom_range(2, 10);
            for (k = 0; k < pool_n; k++)
                pool[k] = pool_value();
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(3))
                0:       append_pct = 25;
                1:       append_pct = 50;
                2:       append_pct = 75;
                default: append_pct = 90;
            endcase
            for (k = 0; k < seg_len; k++)
            begin
                queue_item(($urandom_range(99) < append_pct) ? MODE_APPEND : MODE_DELETE,
                           ($urandom_range(99) < 85) ? pool[$urandom_range(pool_n - 1)]
                                                      : $urandom);
                n++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/olad_pkg.sv
rtl/olad_ram.sv
rtl/ordered_list_append_delete_top.sv
rtl/olad_chk.sv
tb/tb.sv
